// ----- src/slt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the string literal transcoder
// Holds the mode codes, the literal state, the result word and the escape map.
// ----------------------------------------------------------------------------
package slt_pkg;

   localparam int BYTE_W  = 8;
   localparam int MODE_W  = 2;
   localparam int CODE_W  = 21;
   localparam int QUEUE_DEPTH = 4;

   // output modes
   localparam logic [MODE_W-1:0] MODE_RAW   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_UTF16 = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UTF32 = 2'd2;

   // characters and code point limits
   localparam logic [BYTE_W-1:0] BACKSLASH    = 8'h5C;
   localparam logic [CODE_W-1:0] CP_2BYTE_MIN = 21'h00080;
   localparam logic [CODE_W-1:0] CP_3BYTE_MIN = 21'h00800;
   localparam logic [CODE_W-1:0] CP_4BYTE_MIN = 21'h10000;
   localparam logic [CODE_W-1:0] CP_MAX       = 21'h10FFFF;
   localparam logic [CODE_W-1:0] CP_BMP_MAX   = 21'h00FFFF;
   localparam logic [CODE_W-1:0] SURR_LO      = 21'h00D800;
   localparam logic [CODE_W-1:0] SURR_HI      = 21'h00DFFF;
   localparam logic [15:0]       HIGH_SURR    = 16'hD800;
   localparam logic [15:0]       LOW_SURR     = 16'hDC00;

   // continuation counts of a UTF-8 sequence
   localparam logic [1:0] SEQ_TWO   = 2'd1;
   localparam logic [1:0] SEQ_THREE = 2'd2;
   localparam logic [1:0] SEQ_FOUR  = 2'd3;

   typedef struct packed {
      logic              escape_pending;
      logic [1:0]        bytes_left;
      logic [1:0]        seq_length;
      logic [CODE_W-1:0] code_acc;
      logic              drop_rest;
   } slt_state_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_unit;
      logic              error;
      logic              literal_end;
   } slt_result_type;

   typedef struct packed {
      logic [1:0]     count;
      slt_result_type first;
      slt_result_type second;
      slt_state_type  state;
   } slt_step_type;

   typedef struct packed {
      logic              ok;
      logic [BYTE_W-1:0] value;
   } slt_escape_type;

   // map the character after a backslash to its value
   function automatic slt_escape_type escape_map(input logic [BYTE_W-1:0] c);
      slt_escape_type r;
      r.ok = 1'b1;
      case (c)
         8'h6E: r.value = 8'h0A;   // n
         8'h74: r.value = 8'h09;   // t
         8'h72: r.value = 8'h0D;   // r
         8'h5C: r.value = 8'h5C;   // backslash
         8'h27: r.value = 8'h27;   // single quote
         8'h22: r.value = 8'h22;   // double quote
         8'h30: r.value = 8'h00;   // zero
         default: begin
            r.ok    = 1'b0;
            r.value = '0;
         end
      endcase
      return r;
   endfunction

endpackage

// ----- src/slt_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_decode: one-byte decode step
// Escape handling, UTF-8 accumulation and validation, surrogate split and
// error drop for one accepted byte on the current literal state.
// ----------------------------------------------------------------------------
module slt_decode (
   input  logic [slt_pkg::BYTE_W-1:0] byte_in,
   input  logic                       last_in,
   input  logic [slt_pkg::MODE_W-1:0] mode,
   input  slt_pkg::slt_state_type     state_cur,
   output slt_pkg::slt_step_type      step
);

   slt_pkg::slt_state_type         ns;
   slt_pkg::slt_escape_type        esc;
   logic                           fail;
   logic                           emit;
   logic                           split;
   logic [slt_pkg::CODE_W-1:0]     cp;
   logic [slt_pkg::CODE_W-1:0]     acc_next;
   logic [slt_pkg::CODE_W-1:0]     offset;
   logic [1:0]                     left_next;

   // next state and the decoded code point
   always_comb begin
      ns        = state_cur;
      fail      = 1'b0;
      emit      = 1'b0;
      cp        = '0;
      esc       = slt_pkg::escape_map(byte_in);
      acc_next  = {state_cur.code_acc[slt_pkg::CODE_W-7:0], byte_in[5:0]};
      left_next = state_cur.bytes_left - 2'd1;
      if (state_cur.drop_rest) begin
         if (last_in) begin
            ns = '0;
         end
      end else if (state_cur.escape_pending) begin
         ns.escape_pending = 1'b0;
         if (esc.ok) begin
            emit = 1'b1;
            cp   = slt_pkg::CODE_W'(esc.value);
         end else begin
            fail = 1'b1;
         end
      end else if (state_cur.bytes_left != 2'd0) begin
         if (byte_in[7:6] != 2'b10) begin
            fail = 1'b1;
         end else begin
            ns.code_acc   = acc_next;
            ns.bytes_left = left_next;
            if (left_next != 2'd0) begin
               fail = last_in;
            end else if (state_cur.seq_length == slt_pkg::SEQ_TWO &&
                         acc_next < slt_pkg::CP_2BYTE_MIN) begin
               fail = 1'b1;
            end else if (state_cur.seq_length == slt_pkg::SEQ_THREE &&
                         (acc_next < slt_pkg::CP_3BYTE_MIN ||
                          (acc_next >= slt_pkg::SURR_LO &&
                           acc_next <= slt_pkg::SURR_HI))) begin
               fail = 1'b1;
            end else if (state_cur.seq_length == slt_pkg::SEQ_FOUR &&
                         (acc_next < slt_pkg::CP_4BYTE_MIN ||
                          acc_next > slt_pkg::CP_MAX)) begin
               fail = 1'b1;
            end else begin
               ns.seq_length = '0;
               ns.code_acc   = '0;
               emit          = 1'b1;
               cp            = acc_next;
            end
         end
      end else if (byte_in == slt_pkg::BACKSLASH) begin
         if (last_in) begin
            fail = 1'b1;
         end else begin
            ns.escape_pending = 1'b1;
         end
      end else if (mode == slt_pkg::MODE_RAW || !byte_in[7]) begin
         // raw bytes and ASCII pass straight out
         emit = 1'b1;
         cp   = slt_pkg::CODE_W'(byte_in);
      end else if (byte_in[7:5] == 3'b110) begin
         ns.seq_length = slt_pkg::SEQ_TWO;
         ns.bytes_left = slt_pkg::SEQ_TWO;
         ns.code_acc   = slt_pkg::CODE_W'(byte_in[4:0]);
         fail          = last_in;
      end else if (byte_in[7:4] == 4'b1110) begin
         ns.seq_length = slt_pkg::SEQ_THREE;
         ns.bytes_left = slt_pkg::SEQ_THREE;
         ns.code_acc   = slt_pkg::CODE_W'(byte_in[3:0]);
         fail          = last_in;
      end else if (byte_in[7:3] == 5'b11110) begin
         ns.seq_length = slt_pkg::SEQ_FOUR;
         ns.bytes_left = slt_pkg::SEQ_FOUR;
         ns.code_acc   = slt_pkg::CODE_W'(byte_in[2:0]);
         fail          = last_in;
      end else begin
         fail = 1'b1;
      end
      // an error clears the literal and drops the rest unless this was the end
      if (fail) begin
         ns           = '0;
         ns.drop_rest = !last_in;
      end
   end

   // build the result words
   always_comb begin
      split  = emit && mode == slt_pkg::MODE_UTF16 && cp > slt_pkg::CP_BMP_MAX;
      offset = cp - slt_pkg::CP_4BYTE_MIN;
      step.state = ns;
      step.second.code_unit =
         slt_pkg::CODE_W'(slt_pkg::LOW_SURR | {6'd0, offset[9:0]});
      step.second.error       = 1'b0;
      step.second.literal_end = last_in;
      if (fail) begin
         step.count             = 2'd1;
         step.first.code_unit   = '0;
         step.first.error       = 1'b1;
         step.first.literal_end = 1'b1;
      end else if (split) begin
         step.count             = 2'd2;
         step.first.code_unit   =
            slt_pkg::CODE_W'(slt_pkg::HIGH_SURR | {6'd0, offset[19:10]});
         step.first.error       = 1'b0;
         step.first.literal_end = 1'b0;
      end else begin
         step.count             = {1'b0, emit};
         step.first.code_unit   = cp;
         step.first.error       = 1'b0;
         step.first.literal_end = last_in;
      end
   end

endmodule

// ----- src/slt_out_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_out_queue: result word queue
// Takes zero, one or two result words per cycle and hands out one per cycle while pop is high.
// ----------------------------------------------------------------------------
module slt_out_queue #(
   parameter int Depth = slt_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             push_count,
   input  slt_pkg::slt_result_type push_first,
   input  slt_pkg::slt_result_type push_second,
   input  logic                   pop,
   output logic                   head_valid,
   output slt_pkg::slt_result_type head,
   output logic                   room_for_two
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   slt_pkg::slt_result_type slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_plus;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_pop;

   function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
      logic [PtrW-1:0] r;
      if (p == PtrW'(Depth - 1)) begin
         r = '0;
      end else begin
         r = p + PtrW'(1);
      end
      return r;
   endfunction

   // advance pointers and fill count
   always_comb begin
      do_pop      = pop && count_ff != '0;
      wr_ptr_plus = next_ptr(wr_ptr_ff);
      case (push_count)
         2'd1:    wr_ptr_in = wr_ptr_plus;
         2'd2:    wr_ptr_in = next_ptr(wr_ptr_plus);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CntW'(push_count) - CntW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store incoming words
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push_first;
      end
      if (push_count == 2'd2) begin
         slot_ff[wr_ptr_plus] <= push_second;
      end
   end

   assign head_valid   = count_ff != '0;
   assign head         = slot_ff[rd_ptr_ff];
   assign room_for_two = count_ff <= CntW'(Depth - 2);

endmodule

// ----- src/string_literal_transcoder_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_transcoder_unit: string literal body transcoder
// Decodes escapes and UTF-8 in a literal body and emits bytes, UTF-16 code
// units or UTF-32 code points, with one flagged word per malformed literal.
//
//   channel | direction | tdata                     | tuser | tlast
//   req_    | in        | [7:0] byte_req            | -     | last_byte
//   rsp_    | out       | [20:0] code_unit, pad 0   | error | literal_end
//   csr_    | in        | [1:0] out_mode (write)    | -     | -
//
// Each accepted byte is decoded in the cycle it is accepted; its words are
// written into the result queue and leave on rsp_ behind any older words. One
// byte per cycle is taken while the result queue holds at most QueueDepth - 2
// words; a stalled rsp_ side fills the queue and holds req_tready low, and a
// csr_ write holds it low for that cycle. Reset sets out_mode to UTF-32 and
// clears the literal state; a csr_ write also clears the literal state.
// ----------------------------------------------------------------------------
module string_literal_transcoder_unit #(
   parameter int QueueDepth = slt_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_req
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [20:0] code_unit, [23:21] zero
   output logic        rsp_tuser,   // [0] error
   output logic        rsp_tlast,   // literal_end
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data  // out_mode
);

   slt_pkg::slt_state_type      state_ff;
   logic [slt_pkg::MODE_W-1:0]  mode_ff;
   slt_pkg::slt_step_type       step;
   slt_pkg::slt_result_type     head;
   logic                        accept;
   logic                        room_for_two;
   logic [1:0]                  push_count;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = room_for_two && !csr_wr_en;
   assign push_count = accept ? step.count : 2'd0;

   slt_decode u_decode (
      .byte_in   (req_tdata),
      .last_in   (req_tlast),
      .mode      (mode_ff),
      .state_cur (state_ff),
      .step      (step)
   );

   // hold mode and literal state; a register write restarts the literal
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= slt_pkg::MODE_UTF32;
         state_ff <= '0;
      end else if (csr_wr_en) begin
         mode_ff  <= csr_wr_data;
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= step.state;
      end
   end

   slt_out_queue #(
      .Depth (QueueDepth)
   ) u_out_queue (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_first   (step.first),
      .push_second  (step.second),
      .pop          (rsp_tready),
      .head_valid   (rsp_tvalid),
      .head         (head),
      .room_for_two (room_for_two)
   );

   assign rsp_tdata = {3'b000, head.code_unit};
   assign rsp_tuser = head.error;
   assign rsp_tlast = head.literal_end;

endmodule

// ----- src/slt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slt_checker: port checks of the string literal transcoder
// Watches the result channel over time and is bound to the top level.
// ----------------------------------------------------------------------------
module slt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   // an error word carries no code and closes the literal
   a_error_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && rsp_tdata == 24'd0)
      else $error("error word with code or without literal end");

   // no word above the Unicode range
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata <= 24'h10FFFF)
      else $error("code unit out of range");

   // a stalled word holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word after reset");

endmodule

bind string_literal_transcoder_unit slt_checker u_slt_checker (.*);

// ----- dv/string_literal_transcoder_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_literal_transcoder_unit_tb: self-checking bench of the literal transcoder
// Streams literal bodies through the block in raw, UTF-16 and UTF-32 modes.
// A tracker decodes every accepted byte on its own and queues the expected
// words; each word leaving the block is checked against the oldest one.
// Directed literals hit the escapes, the code point limits and several error
// paths; random phases then mix well-formed text with injected faults, while
// both sides stall, and the mode register is rewritten between phases.
// ----------------------------------------------------------------------------
module string_literal_transcoder_unit_tb;

   localparam logic [slt_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;   // decodes as UTF-32
   localparam int CLK_HALF_NS   = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_BYTES  = 1650;
   localparam int RUN_LIMIT_NS  = 5_000_000;

   // characters that may follow a backslash: n t r \ ' " 0
   localparam bit [7:0] ESCAPE_CHARS [7] = '{8'h6E, 8'h74, 8'h72, 8'h5C, 8'h27, 8'h22, 8'h30};

   // -------------------------------------------------------------------------
   // Expected word tracker: decodes bytes, holds expected words, checks words
   // -------------------------------------------------------------------------
   class transcode_tracker;
      slt_pkg::slt_result_type expected_units[$];
      logic [1:0]     mode;
      bit             esc_seen;
      bit [1:0]       cont_left;
      bit [1:0]       cont_total;
      bit [20:0]      acc;
      bit             dropping;
      int             mismatches;
      int             bytes_decoded;
      int             units_checked;
      int             error_words;
      int             surrogate_pairs;

      function new();
         set_mode(slt_pkg::MODE_UTF32);
      endfunction

      function void clear_literal();
         esc_seen   = 1'b0;
         cont_left  = '0;
         cont_total = '0;
         acc        = '0;
         dropping   = 1'b0;
      endfunction

      // a mode write also wipes any half-decoded literal
      function void set_mode(logic [1:0] m);
         mode = m;
         clear_literal();
      endfunction

      function int pending();
         return expected_units.size();
      endfunction

      function bit unescape(input bit [7:0] c, output bit [7:0] v);
         v = '0;
         case (c)
            8'h6E:   begin v = 8'h0A; return 1'b1; end
            8'h74:   begin v = 8'h09; return 1'b1; end
            8'h72:   begin v = 8'h0D; return 1'b1; end
            8'h5C:   begin v = 8'h5C; return 1'b1; end
            8'h27:   begin v = 8'h27; return 1'b1; end
            8'h22:   begin v = 8'h22; return 1'b1; end
            8'h30:   begin v = 8'h00; return 1'b1; end
            default: return 1'b0;
         endcase
      endfunction

      function void push_unit(bit [20:0] cu, bit err, bit fin);
         slt_pkg::slt_result_type w;
         w.code_unit   = cu;
         w.error       = err;
         w.literal_end = fin;
         expected_units.push_back(w);
      endfunction

      // flag the literal; drop what follows unless this was its last byte
      function void reject(bit last);
         clear_literal();
         dropping = !last;
         push_unit('0, 1'b1, 1'b1);
         error_words++;
      endfunction

      // split supplementary points into a surrogate pair in UTF-16 mode
      function void emit_point(bit [20:0] cp, bit last);
         bit [20:0] t;
         if (mode == slt_pkg::MODE_UTF16 && cp > slt_pkg::CP_BMP_MAX) begin
            t = cp - slt_pkg::CP_4BYTE_MIN;
            push_unit(21'(slt_pkg::HIGH_SURR) | 21'(t[19:10]), 1'b0, 1'b0);
            push_unit(21'(slt_pkg::LOW_SURR) | 21'(t[9:0]), 1'b0, last);
            surrogate_pairs++;
         end else begin
            push_unit(cp, 1'b0, last);
         end
      endfunction

      function void note_byte(bit [7:0] b, bit last);
         bit [7:0]  esc_val;
         bit [20:0] cp;
         bytes_decoded++;
         // swallow the rest of a failed literal
         if (dropping) begin
            if (last) clear_literal();
            return;
         end
         if (esc_seen) begin
            esc_seen = 1'b0;
            if (unescape(b, esc_val)) push_unit(21'(esc_val), 1'b0, last);
            else reject(last);
            return;
         end
         // inside a UTF-8 sequence
         if (cont_left != 0) begin
            if (b[7:6] != 2'b10) begin
               reject(last);
               return;
            end
            acc = {acc[14:0], b[5:0]};
            cont_left--;
            if (cont_left != 0) begin
               if (last) reject(last);
               return;
            end
            cp = acc;
            if ((cont_total == slt_pkg::SEQ_TWO && cp < slt_pkg::CP_2BYTE_MIN) ||
                (cont_total == slt_pkg::SEQ_THREE &&
                 (cp < slt_pkg::CP_3BYTE_MIN ||
                  (cp >= slt_pkg::SURR_LO && cp <= slt_pkg::SURR_HI))) ||
                (cont_total == slt_pkg::SEQ_FOUR &&
                 (cp < slt_pkg::CP_4BYTE_MIN || cp > slt_pkg::CP_MAX))) begin
               reject(last);
               return;
            end
            cont_total = '0;
            acc        = '0;
            emit_point(cp, last);
            return;
         end
         if (b == slt_pkg::BACKSLASH) begin
            if (last) reject(last);
            else esc_seen = 1'b1;
            return;
         end
         if (mode == slt_pkg::MODE_RAW) begin
            push_unit(21'(b), 1'b0, last);
            return;
         end
         if (b[7] == 1'b0) begin
            emit_point(21'(b), last);
            return;
         end
         // lead byte: open a sequence
         if (b[7:5] == 3'b110) begin
            cont_total = slt_pkg::SEQ_TWO;
            acc        = 21'(b[4:0]);
         end else if (b[7:4] == 4'b1110) begin
            cont_total = slt_pkg::SEQ_THREE;
            acc        = 21'(b[3:0]);
         end else if (b[7:3] == 5'b11110) begin
            cont_total = slt_pkg::SEQ_FOUR;
            acc        = 21'(b[2:0]);
         end else begin
            reject(last);
            return;
         end
         cont_left = cont_total;
         if (last) reject(last);
      endfunction

      function void check_word(logic [23:0] data, logic user, logic fin);
         slt_pkg::slt_result_type want;
         if (expected_units.size() == 0) begin
            $display("[%0t] unexpected word: code_unit=%h error=%b literal_end=%b",
                     $time, data, user, fin);
            mismatches++;
            return;
         end
         want = expected_units.pop_front();
         units_checked++;
         if (data !== {3'b000, want.code_unit}) begin
            $display("[%0t] code_unit mismatch: expected %h, actual %h",
                     $time, want.code_unit, data);
            mismatches++;
         end
         if (user !== want.error) begin
            $display("[%0t] error mismatch: expected %b, actual %b", $time, want.error, user);
            mismatches++;
         end
         if (fin !== want.literal_end) begin
            $display("[%0t] literal_end mismatch: expected %b, actual %b",
                     $time, want.literal_end, fin);
            mismatches++;
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block
   // -------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_wr_data = '0;

   transcode_tracker transcoded = new();
   bit [7:0]         lit[$];
   bit               hold_rsp      = 1'b0;
   bit               steady_sender = 1'b0;
   int               burst_left    = 0;
   int               modes_written = 0;

   always begin
      #CLK_HALF_NS clock = 1'b1;
      #CLK_HALF_NS clock = 1'b0;
   end

   string_literal_transcoder_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Sample every handshake and register write at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) transcoded.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
         if (req_tvalid && req_tready) transcoded.note_byte(req_tdata, req_tlast);
         if (csr_wr_en) transcoded.set_mode(csr_wr_data);
      end
   end

   // Receiver: stall pattern changes every span, with an occasional long hold
   initial begin : receiver
      int       style;
      int       span;
      bit [7:0] tick;
      tick = '0;
      forever begin
         style = $urandom_range(0, 4);
         span  = $urandom_range(20, 200);
         repeat (span) begin
            if (hold_rsp) begin
               hold_rsp = 1'b0;
               rsp_tready <= 1'b0;
               repeat (LONG_HOLD) @(posedge clock);
            end
            case (style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= ($urandom_range(0, 3) != 0);
               2:       rsp_tready <= (tick[1:0] != 2'b11);
               3:       rsp_tready <= tick[3];
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
            tick++;
            @(posedge clock);
         end
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("Some tests failed");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Literal builders
   // -------------------------------------------------------------------------
   function automatic bit [20:0] pick_in(bit [20:0] lo, bit [20:0] hi);
      case ($urandom_range(0, 7))
         0:       return lo;
         1:       return hi;
         default: return 21'($urandom_range(hi, lo));
      endcase
   endfunction

   // encode with a forced length, so overlong forms come out too
   function automatic void push_utf8(bit [20:0] cp, int len);
      case (len)
         1: lit.push_back({1'b0, cp[6:0]});
         2: begin
            lit.push_back({3'b110, cp[10:6]});
            lit.push_back({2'b10, cp[5:0]});
         end
         3: begin
            lit.push_back({4'b1110, cp[15:12]});
            lit.push_back({2'b10, cp[11:6]});
            lit.push_back({2'b10, cp[5:0]});
         end
         default: begin
            lit.push_back({5'b11110, cp[20:18]});
            lit.push_back({2'b10, cp[17:12]});
            lit.push_back({2'b10, cp[11:6]});
            lit.push_back({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic void add_char(logic [1:0] m);
      int        r;
      bit [7:0]  b;
      bit [20:0] cp;
      r = $urandom_range(0, 99);
      if (r < 30) begin
         cp = 21'($urandom_range(0, 127));
         if (cp == 21'(slt_pkg::BACKSLASH)) cp = 21'h7F;
         push_utf8(cp, 1);
      end else if (r < 48) begin
         lit.push_back(slt_pkg::BACKSLASH);
         lit.push_back(ESCAPE_CHARS[$urandom_range(0, 6)]);
      end else if (m == slt_pkg::MODE_RAW && r < 75) begin
         b = 8'($urandom_range(0, 255));
         if (b == slt_pkg::BACKSLASH) b = 8'hFF;
         lit.push_back(b);
      end else if (r < 62) begin
         push_utf8(pick_in(slt_pkg::CP_2BYTE_MIN, slt_pkg::CP_3BYTE_MIN - 1), 2);
      end else if (r < 82) begin
         // move surrogates up into the top of the plane
         cp = pick_in(slt_pkg::CP_3BYTE_MIN, slt_pkg::CP_BMP_MAX);
         if (cp >= slt_pkg::SURR_LO && cp <= slt_pkg::SURR_HI) cp ^= 21'h2000;
         push_utf8(cp, 3);
      end else begin
         push_utf8(pick_in(slt_pkg::CP_4BYTE_MIN, slt_pkg::CP_MAX), 4);
      end
   endfunction

   function automatic void add_fault(logic [1:0] m);
      int       r;
      int       len;
      bit [7:0] c;
      bit [7:0] scratch;
      r = (m == slt_pkg::MODE_RAW) ? 0 : $urandom_range(0, 8);
      case (r)
         // unknown escape
         0: begin
            do c = 8'($urandom_range(0, 255)); while (transcoded.unescape(c, scratch));
            lit.push_back(slt_pkg::BACKSLASH);
            lit.push_back(c);
         end
         // overlong forms
         1: push_utf8(pick_in(0, slt_pkg::CP_2BYTE_MIN - 1), 2);
         2: push_utf8(pick_in(0, slt_pkg::CP_3BYTE_MIN - 1), 3);
         3: push_utf8(pick_in(0, slt_pkg::CP_BMP_MAX), 4);
         4: push_utf8(pick_in(slt_pkg::SURR_LO, slt_pkg::SURR_HI), 3);
         5: push_utf8(pick_in(slt_pkg::CP_MAX + 1, 21'h1FFFFF), 4);
         // bad lead byte
         6: begin
            if ($urandom_range(0, 1) == 0) lit.push_back(8'($urandom_range(8'h80, 8'hBF)));
            else lit.push_back(8'($urandom_range(8'hF8, 8'hFF)));
         end
         // bad continuation byte
         7: begin
            len = $urandom_range(2, 4);
            push_utf8(pick_in(0, slt_pkg::CP_MAX), len);
            c = 8'($urandom_range(0, 255));
            if (c[7:6] == 2'b10) c[6] = 1'b1;
            lit[lit.size() - $urandom_range(1, len - 1)] = c;
         end
         // sequence cut short
         default: begin
            len = $urandom_range(2, 4);
            push_utf8(pick_in(slt_pkg::CP_2BYTE_MIN, slt_pkg::CP_MAX), len);
            repeat ($urandom_range(1, len - 1)) void'(lit.pop_back());
         end
      endcase
   endfunction

   function automatic void build_literal(logic [1:0] m);
      int r;
      int n_chars;
      int fault_at;
      lit.delete();
      r = $urandom_range(0, 99);
      // plain byte noise
      if (r < 8) begin
         repeat ($urandom_range(1, 10)) lit.push_back(8'($urandom_range(0, 255)));
         return;
      end
      n_chars  = (r < 85) ? $urandom_range(1, 8) : $urandom_range(9, 24);
      fault_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_chars - 1) : -1;
      for (int k = 0; k < n_chars; k++) begin
         if (k == fault_at) add_fault(m);
         else add_char(m);
      end
      // now and then end on a lone backslash
      if ($urandom_range(0, 24) == 0) lit.push_back(slt_pkg::BACKSLASH);
   endfunction

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   // burst pacing: a random gap before each new burst, none in steady phases
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady_sender ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_byte(bit [7:0] b, bit last);
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // send the built literal; an open one leaves its last byte unmarked
   task automatic send_literal(bit open_end);
      for (int k = 0; k < lit.size(); k++) begin
         pace();
         send_byte(lit[k], !open_end && k == lit.size() - 1);
      end
   endtask

   // hold input until every expected word is out, then let the block settle
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (transcoded.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mode(logic [1:0] m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      modes_written++;
   endtask

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int         phase;
      int         phase_len;
      int         sent;
      int         start_bytes;
      logic [1:0] mode_sel;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // UTF-32 from reset: last ASCII, an escape, the top code point
      lit = '{8'h7F, slt_pkg::BACKSLASH, 8'h6E, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
      send_literal(1'b0);
      // overlong pair, then the trailing byte is dropped
      lit = '{8'hC0, 8'h80, 8'h41};
      send_literal(1'b0);
      // sequence open at the last byte
      lit = '{8'hE1};
      send_literal(1'b0);
      settle();

      // UTF-16: tab escape and the lowest supplementary point as a pair
      write_mode(slt_pkg::MODE_UTF16);
      lit = '{slt_pkg::BACKSLASH, 8'h74, 8'hF0, 8'h90, 8'h80, 8'h80};
      send_literal(1'b0);
      // encoded surrogate
      lit = '{8'hED, 8'hA0, 8'h80};
      send_literal(1'b0);
      settle();

      // raw: high and zero bytes, escaped backslash, then a trailing backslash
      write_mode(slt_pkg::MODE_RAW);
      lit = '{8'hFF, 8'h00, slt_pkg::BACKSLASH, slt_pkg::BACKSLASH, slt_pkg::BACKSLASH};
      send_literal(1'b0);
      settle();

      // spare mode code: unknown escape mid-literal, rest dropped
      write_mode(MODE_SPARE);
      lit = '{slt_pkg::BACKSLASH, 8'h71, 8'h41};
      send_literal(1'b0);
      settle();

      // random phases, one mode setting each
      start_bytes = transcoded.bytes_decoded;
      phase = 0;
      while (transcoded.bytes_decoded - start_bytes < RANDOM_BYTES) begin
         mode_sel = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
         write_mode(mode_sel);
         steady_sender = ($urandom_range(0, 4) == 0);
         if (phase == 2 || phase == 9) hold_rsp = 1'b1;
         phase_len = $urandom_range(60, 200);
         sent = 0;
         while (sent < phase_len) begin
            build_literal(mode_sel);
            send_literal(1'b0);
            sent += lit.size();
         end
         // sometimes leave a literal unfinished; the next mode write clears it
         if ($urandom_range(0, 3) == 0) begin
            build_literal(mode_sel);
            send_literal(1'b1);
         end
         settle();
         phase++;
      end

      $display("Covered %0d accepted bytes over %0d mode writes; %0d words checked,",
               transcoded.bytes_decoded, modes_written, transcoded.units_checked);
      $display("  of them %0d error words and %0d surrogate pairs",
               transcoded.error_words, transcoded.surrogate_pairs);
      if (transcoded.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
